// ===== hdl/raff_pkg.sv =====
// shared types and constants of the rectangle affine transformer
// mode codes, decoded ops, register indexes and interface structs; no dependencies
`default_nettype none

package raff_pkg;

   localparam int CORNERS     = 4;
   localparam int OUT_WIDTH   = 32;
   localparam int FRAC_BITS   = 30;
   localparam int COEF_WIDTH  = 33;
   localparam int LO_WIDTH    = 64;
   localparam int QUEUE_DEPTH = 2;
   localparam int CSR_IDX_W   = 3;

   // request mode codes
   localparam logic [3:0] MODE_LOAD    = 4'd0;
   localparam logic [3:0] MODE_UP      = 4'd1;
   localparam logic [3:0] MODE_DOWN    = 4'd2;
   localparam logic [3:0] MODE_LEFT    = 4'd3;
   localparam logic [3:0] MODE_RIGHT   = 4'd4;
   localparam logic [3:0] MODE_GROW    = 4'd5;
   localparam logic [3:0] MODE_SHRINK  = 4'd6;
   localparam logic [3:0] MODE_ROT_POS = 4'd7;
   localparam logic [3:0] MODE_ROT_NEG = 4'd8;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MOVE_STEP     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GROW_FACTOR   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SHRINK_FACTOR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_COSINE    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROT_SINE      = 3'd4;

   localparam logic [30:0]        RST_MOVE_STEP     = 31'd65536;
   localparam logic [30:0]        RST_GROW_FACTOR   = 31'd1074815566;
   localparam logic [30:0]        RST_SHRINK_FACTOR = 31'd1072668082;
   localparam logic signed [31:0] RST_ROT_COSINE    = 32'sd1073740189;
   localparam logic signed [31:0] RST_ROT_SINE      = 32'sd1874032;

   typedef enum logic [3:0] {
      OP_LOAD,
      OP_UP,
      OP_DOWN,
      OP_LEFT,
      OP_RIGHT,
      OP_GROW,
      OP_SHRINK,
      OP_ROT_POS,
      OP_ROT_NEG,
      OP_HOLD
   } op_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_DELTA,
      PH_MULT,
      PH_SUM,
      PH_WRITE
   } phase_type;

   typedef struct packed {
      logic [30:0]        move_step;
      logic [30:0]        grow_factor;
      logic [30:0]        shrink_factor;
      logic signed [31:0] rot_cosine;
      logic signed [31:0] rot_sine;
   } cfg_type;

   typedef struct packed {
      op_type             op;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic [30:0]        rect_width;
      logic [30:0]        rect_height;
   } entry_type;

   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

   typedef struct packed {
      logic pop;
      logic busy;
      logic finish;
   } bk_ctl_type;

   typedef struct packed {
      logic [CORNERS-1:0][OUT_WIDTH-1:0] x;
      logic [CORNERS-1:0][OUT_WIDTH-1:0] y;
      logic                              saturated;
   } rsp_type;

endpackage

`default_nettype wire

// ===== hdl/raff_front.sv =====
// front end: takes request beats, decodes the mode and queues the decoded entries
// depends on raff_pkg
`default_nettype none

module raff_front (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [3:0]           req_mode,
   input  wire logic signed [31:0]   req_origin_x,
   input  wire logic signed [31:0]   req_origin_y,
   input  wire logic [30:0]          req_rect_width,
   input  wire logic [30:0]          req_rect_height,
   input  wire logic                 pop,
   output raff_pkg::head_type        head
);

   localparam int PTRW = (raff_pkg::QUEUE_DEPTH > 1) ? $clog2(raff_pkg::QUEUE_DEPTH) : 1;
   localparam int CNTW = $clog2(raff_pkg::QUEUE_DEPTH + 1);
   localparam logic [PTRW-1:0] LAST_PTR = PTRW'(raff_pkg::QUEUE_DEPTH - 1);
   localparam logic [CNTW-1:0] FULL_CNT = CNTW'(raff_pkg::QUEUE_DEPTH);

   raff_pkg::entry_type queue_ff [raff_pkg::QUEUE_DEPTH];
   raff_pkg::entry_type new_entry;
   logic [PTRW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTRW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]     count_ff, count_in;
   logic                push;

   always_comb begin
      new_entry.origin_x    = req_origin_x;
      new_entry.origin_y    = req_origin_y;
      new_entry.rect_width  = req_rect_width;
      new_entry.rect_height = req_rect_height;
      case (req_mode)
         raff_pkg::MODE_LOAD:    new_entry.op = raff_pkg::OP_LOAD;
         raff_pkg::MODE_UP:      new_entry.op = raff_pkg::OP_UP;
         raff_pkg::MODE_DOWN:    new_entry.op = raff_pkg::OP_DOWN;
         raff_pkg::MODE_LEFT:    new_entry.op = raff_pkg::OP_LEFT;
         raff_pkg::MODE_RIGHT:   new_entry.op = raff_pkg::OP_RIGHT;
         raff_pkg::MODE_GROW:    new_entry.op = raff_pkg::OP_GROW;
         raff_pkg::MODE_SHRINK:  new_entry.op = raff_pkg::OP_SHRINK;
         raff_pkg::MODE_ROT_POS: new_entry.op = raff_pkg::OP_ROT_POS;
         raff_pkg::MODE_ROT_NEG: new_entry.op = raff_pkg::OP_ROT_NEG;
         default:                new_entry.op = raff_pkg::OP_HOLD;
      endcase
   end

   assign req_ready  = (count_ff != FULL_CNT);
   assign push       = req_valid && req_ready;
   assign head.valid = (count_ff != '0);
   assign head.entry = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

`default_nettype wire

// ===== hdl/raff_back.sv =====
// back end: holds the corners, runs load and translate straight from the queue head and
// scale/rotate through a delta, multiply, sum and write sequence; depends on raff_pkg
`default_nettype none

module raff_back #(
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire raff_pkg::cfg_type   cfg,
   input  wire raff_pkg::head_type  head,
   output raff_pkg::bk_ctl_type     ctl,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output raff_pkg::rsp_type        rsp_data
);

   localparam int W    = COORD_WIDTH;
   localparam int FB   = raff_pkg::FRAC_BITS;
   localparam int CW   = raff_pkg::COEF_WIDTH;
   localparam int LW   = raff_pkg::LO_WIDTH;
   localparam int EXTW = (W + 1 > FB + 1) ? W + 1 : FB + 1;
   localparam int HW   = EXTW - FB;
   localparam int HPW  = HW + CW;
   localparam int HIW  = HPW + 1;
   localparam int NW   = HIW + 1;
   localparam int VW   = NW + 1;
   localparam int TW   = LW - FB;

   localparam logic signed [W-1:0]  CMAX    = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0]  CMIN    = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [VW-1:0] VMAX    = VW'(CMAX);
   localparam logic signed [VW-1:0] VMIN    = VW'(CMIN);
   localparam logic signed [LW-1:0] LO_HALF = LW'(1) << (FB - 1);

   function automatic logic signed [W-1:0] clamp_v(input logic signed [VW-1:0] v);
      logic signed [W-1:0] r;
      if (v > VMAX) begin
         r = CMAX;
      end else if (v < VMIN) begin
         r = CMIN;
      end else begin
         r = v[W-1:0];
      end
      return r;
   endfunction

   function automatic logic sat_v(input logic signed [VW-1:0] v);
      return (v > VMAX) || (v < VMIN);
   endfunction

   // corner state
   logic signed [W-1:0] cx_ff [raff_pkg::CORNERS];
   logic signed [W-1:0] cy_ff [raff_pkg::CORNERS];
   logic signed [W-1:0] cx_in [raff_pkg::CORNERS];
   logic signed [W-1:0] cy_in [raff_pkg::CORNERS];

   raff_pkg::phase_type phase_ff, phase_in;
   logic                rsp_valid_ff, rsp_valid_in;
   raff_pkg::rsp_type   rsp_data_ff, rsp_data_in;
   logic                sat_in;
   logic                start;
   logic                out_free;

   // immediate ops
   logic signed [W-1:0]  imm_x [raff_pkg::CORNERS];
   logic signed [W-1:0]  imm_y [raff_pkg::CORNERS];
   logic                 imm_sat;
   logic signed [VW-1:0] step_s, dmx, dmy, w_s, h_s, ox_s, oy_s, yh_s, xw_s;
   logic signed [W-1:0]  ld_x, ld_y;
   logic signed [VW-1:0] tr_x [raff_pkg::CORNERS];
   logic signed [VW-1:0] tr_y [raff_pkg::CORNERS];

   // scale / rotate datapath
   logic signed [W:0]    csum_x, csum_y;
   logic signed [W-1:0]  ctr_x_ff, ctr_x_in, ctr_y_ff, ctr_y_in;
   logic signed [CW-1:0] cax_ff, cax_in, cbx_ff, cbx_in, cay_ff, cay_in, cby_ff, cby_in;
   logic signed [CW-1:0] fac_s, sin_s, cos_s, s_s;
   logic signed [EXTW-1:0] dx_w [raff_pkg::CORNERS];
   logic signed [EXTW-1:0] dy_w [raff_pkg::CORNERS];
   logic [FB-1:0]          dlo_x_ff [raff_pkg::CORNERS];
   logic [FB-1:0]          dlo_y_ff [raff_pkg::CORNERS];
   logic signed [HW-1:0]   dhi_x_ff [raff_pkg::CORNERS];
   logic signed [HW-1:0]   dhi_y_ff [raff_pkg::CORNERS];
   logic signed [LW-1:0]   pl_xa_ff [raff_pkg::CORNERS];
   logic signed [LW-1:0]   pl_xb_ff [raff_pkg::CORNERS];
   logic signed [LW-1:0]   pl_ya_ff [raff_pkg::CORNERS];
   logic signed [LW-1:0]   pl_yb_ff [raff_pkg::CORNERS];
   logic signed [HPW-1:0]  ph_xa_ff [raff_pkg::CORNERS];
   logic signed [HPW-1:0]  ph_xb_ff [raff_pkg::CORNERS];
   logic signed [HPW-1:0]  ph_ya_ff [raff_pkg::CORNERS];
   logic signed [HPW-1:0]  ph_yb_ff [raff_pkg::CORNERS];
   logic signed [HIW-1:0]  sh_x_ff [raff_pkg::CORNERS];
   logic signed [HIW-1:0]  sh_y_ff [raff_pkg::CORNERS];
   logic signed [LW-1:0]   sl_x_ff [raff_pkg::CORNERS];
   logic signed [LW-1:0]   sl_y_ff [raff_pkg::CORNERS];
   logic signed [TW-1:0]   lt_x [raff_pkg::CORNERS];
   logic signed [TW-1:0]   lt_y [raff_pkg::CORNERS];
   logic signed [NW-1:0]   n_x [raff_pkg::CORNERS];
   logic signed [NW-1:0]   n_y [raff_pkg::CORNERS];
   logic signed [VW-1:0]   v_x [raff_pkg::CORNERS];
   logic signed [VW-1:0]   v_y [raff_pkg::CORNERS];
   logic signed [W-1:0]    wb_x [raff_pkg::CORNERS];
   logic signed [W-1:0]    wb_y [raff_pkg::CORNERS];
   logic                   wb_sat;

   // load and translate
   always_comb begin
      imm_sat = 1'b0;
      step_s  = VW'($signed({1'b0, cfg.move_step}));
      w_s     = VW'($signed({1'b0, head.entry.rect_width}));
      h_s     = VW'($signed({1'b0, head.entry.rect_height}));
      ox_s    = VW'(head.entry.origin_x);
      oy_s    = VW'(head.entry.origin_y);
      ld_x    = clamp_v(ox_s);
      ld_y    = clamp_v(oy_s);
      yh_s    = VW'(ld_y) - h_s;
      xw_s    = VW'(ld_x) + w_s;
      dmx     = '0;
      dmy     = '0;
      case (head.entry.op)
         raff_pkg::OP_UP:    dmy = -step_s;
         raff_pkg::OP_DOWN:  dmy = step_s;
         raff_pkg::OP_LEFT:  dmx = -step_s;
         raff_pkg::OP_RIGHT: dmx = step_s;
         default: ;
      endcase
      for (int i = 0; i < raff_pkg::CORNERS; i++) begin
         tr_x[i]  = VW'(cx_ff[i]) + dmx;
         tr_y[i]  = VW'(cy_ff[i]) + dmy;
         imm_x[i] = cx_ff[i];
         imm_y[i] = cy_ff[i];
      end
      case (head.entry.op)
         raff_pkg::OP_LOAD: begin
            imm_x[0] = ld_x;
            imm_y[0] = ld_y;
            imm_x[1] = ld_x;
            imm_y[1] = clamp_v(yh_s);
            imm_x[2] = clamp_v(xw_s);
            imm_y[2] = clamp_v(yh_s);
            imm_x[3] = clamp_v(xw_s);
            imm_y[3] = ld_y;
            imm_sat  = sat_v(ox_s) | sat_v(oy_s) | sat_v(yh_s) | sat_v(xw_s);
         end
         raff_pkg::OP_UP, raff_pkg::OP_DOWN, raff_pkg::OP_LEFT, raff_pkg::OP_RIGHT: begin
            for (int i = 0; i < raff_pkg::CORNERS; i++) begin
               imm_x[i] = clamp_v(tr_x[i]);
               imm_y[i] = clamp_v(tr_y[i]);
               imm_sat  = imm_sat | sat_v(tr_x[i]) | sat_v(tr_y[i]);
            end
         end
         default: ;
      endcase
   end

   // center and coefficients, loaded when a scale or rotate starts
   always_comb begin
      csum_x   = (W+1)'(cx_ff[0]) + (W+1)'(cx_ff[2]);
      csum_y   = (W+1)'(cy_ff[0]) + (W+1)'(cy_ff[2]);
      ctr_x_in = csum_x[W:1];
      ctr_y_in = csum_y[W:1];
      fac_s    = (head.entry.op == raff_pkg::OP_GROW) ?
                 CW'($signed({1'b0, cfg.grow_factor})) :
                 CW'($signed({1'b0, cfg.shrink_factor}));
      sin_s    = CW'(cfg.rot_sine);
      cos_s    = CW'(cfg.rot_cosine);
      s_s      = (head.entry.op == raff_pkg::OP_ROT_POS) ? sin_s : -sin_s;
      if (head.entry.op inside {raff_pkg::OP_GROW, raff_pkg::OP_SHRINK}) begin
         cax_in = fac_s;
         cbx_in = '0;
         cay_in = '0;
         cby_in = fac_s;
      end else begin
         cax_in = cos_s;
         cbx_in = -s_s;
         cay_in = s_s;
         cby_in = cos_s;
      end
   end

   // datapath stages run every cycle; operands hold still while an item is in flight
   always_comb begin
      wb_sat = 1'b0;
      for (int i = 0; i < raff_pkg::CORNERS; i++) begin
         dx_w[i]  = EXTW'(cx_ff[i]) - EXTW'(ctr_x_ff);
         dy_w[i]  = EXTW'(cy_ff[i]) - EXTW'(ctr_y_ff);
         // the rounding half sits in the low sum, so only the top bits carry on
         lt_x[i]  = $signed(sl_x_ff[i][LW-1:FB]);
         lt_y[i]  = $signed(sl_y_ff[i][LW-1:FB]);
         n_x[i]   = NW'(sh_x_ff[i]) + NW'(lt_x[i]);
         n_y[i]   = NW'(sh_y_ff[i]) + NW'(lt_y[i]);
         v_x[i]   = VW'(ctr_x_ff) + VW'(n_x[i]);
         v_y[i]   = VW'(ctr_y_ff) + VW'(n_y[i]);
         wb_x[i]  = clamp_v(v_x[i]);
         wb_y[i]  = clamp_v(v_y[i]);
         wb_sat   = wb_sat | sat_v(v_x[i]) | sat_v(v_y[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         ctr_x_ff <= ctr_x_in;
         ctr_y_ff <= ctr_y_in;
         cax_ff   <= cax_in;
         cbx_ff   <= cbx_in;
         cay_ff   <= cay_in;
         cby_ff   <= cby_in;
      end
      for (int i = 0; i < raff_pkg::CORNERS; i++) begin
         dlo_x_ff[i] <= dx_w[i][FB-1:0];
         dlo_y_ff[i] <= dy_w[i][FB-1:0];
         dhi_x_ff[i] <= dx_w[i][EXTW-1:FB];
         dhi_y_ff[i] <= dy_w[i][EXTW-1:FB];
         pl_xa_ff[i] <= $signed({1'b0, dlo_x_ff[i]}) * cax_ff;
         pl_xb_ff[i] <= $signed({1'b0, dlo_y_ff[i]}) * cbx_ff;
         pl_ya_ff[i] <= $signed({1'b0, dlo_x_ff[i]}) * cay_ff;
         pl_yb_ff[i] <= $signed({1'b0, dlo_y_ff[i]}) * cby_ff;
         ph_xa_ff[i] <= dhi_x_ff[i] * cax_ff;
         ph_xb_ff[i] <= dhi_y_ff[i] * cbx_ff;
         ph_ya_ff[i] <= dhi_x_ff[i] * cay_ff;
         ph_yb_ff[i] <= dhi_y_ff[i] * cby_ff;
         sh_x_ff[i]  <= HIW'(ph_xa_ff[i]) + HIW'(ph_xb_ff[i]);
         sh_y_ff[i]  <= HIW'(ph_ya_ff[i]) + HIW'(ph_yb_ff[i]);
         sl_x_ff[i]  <= pl_xa_ff[i] + pl_xb_ff[i] + LO_HALF;
         sl_y_ff[i]  <= pl_ya_ff[i] + pl_yb_ff[i] + LO_HALF;
      end
   end

   // sequencer
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      phase_in   = phase_ff;
      ctl.pop    = 1'b0;
      ctl.finish = 1'b0;
      ctl.busy   = (phase_ff != raff_pkg::PH_IDLE);
      start      = 1'b0;
      sat_in     = 1'b0;
      for (int i = 0; i < raff_pkg::CORNERS; i++) begin
         cx_in[i] = cx_ff[i];
         cy_in[i] = cy_ff[i];
      end
      case (phase_ff)
         raff_pkg::PH_IDLE: begin
            if (head.valid) begin
               if (head.entry.op inside {raff_pkg::OP_GROW, raff_pkg::OP_SHRINK,
                                         raff_pkg::OP_ROT_POS, raff_pkg::OP_ROT_NEG}) begin
                  start    = 1'b1;
                  ctl.pop  = 1'b1;
                  phase_in = raff_pkg::PH_DELTA;
               end else if (out_free) begin
                  ctl.pop    = 1'b1;
                  ctl.finish = 1'b1;
                  sat_in     = imm_sat;
                  for (int i = 0; i < raff_pkg::CORNERS; i++) begin
                     cx_in[i] = imm_x[i];
                     cy_in[i] = imm_y[i];
                  end
               end
            end
         end
         raff_pkg::PH_DELTA: phase_in = raff_pkg::PH_MULT;
         raff_pkg::PH_MULT:  phase_in = raff_pkg::PH_SUM;
         raff_pkg::PH_SUM:   phase_in = raff_pkg::PH_WRITE;
         raff_pkg::PH_WRITE: begin
            if (out_free) begin
               ctl.finish = 1'b1;
               sat_in     = wb_sat;
               phase_in   = raff_pkg::PH_IDLE;
               for (int i = 0; i < raff_pkg::CORNERS; i++) begin
                  cx_in[i] = wb_x[i];
                  cy_in[i] = wb_y[i];
               end
            end
         end
         default: phase_in = raff_pkg::PH_IDLE;
      endcase

      rsp_valid_in = ctl.finish || (rsp_valid_ff && !rsp_ready);
      for (int i = 0; i < raff_pkg::CORNERS; i++) begin
         rsp_data_in.x[i] = raff_pkg::OUT_WIDTH'(cx_in[i]);
         rsp_data_in.y[i] = raff_pkg::OUT_WIDTH'(cy_in[i]);
      end
      rsp_data_in.saturated = sat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= raff_pkg::PH_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < raff_pkg::CORNERS; i++) begin
            cx_ff[i] <= '0;
            cy_ff[i] <= '0;
         end
      end else begin
         phase_ff     <= phase_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < raff_pkg::CORNERS; i++) begin
            cx_ff[i] <= cx_in[i];
            cy_ff[i] <= cy_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.finish) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hdl/rectangle_affine_transformer.sv =====
// top level of the rectangle affine transformer: control registers, front queue, back end
// depends on raff_pkg, raff_front and raff_back
//
//   channel   signals                              beat when
//   req       req_valid/ready, mode, origin, size  req_valid && req_ready
//   rsp       rsp_valid/ready, four corners, sat   rsp_valid && rsp_ready
//   csr       csr_we, csr_index, csr_wdata         csr_we
//
// load, translate and unused modes run one per cycle while the output register is free.
// grow, shrink and rotate step through center, delta, multiply, sum and write:
// the corner update feeds the next item, so no new item starts until the write is done.
// a two-entry queue between front and back keeps taking requests while the back is busy
// or a result waits in the output register; rsp_ready low holds the back at its write.
// synchronous reset clears the corners to zero, loads the register defaults, empties the queue.
`default_nettype none

module rectangle_affine_transformer #(
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [3:0]                        req_mode,
   input  wire logic signed [31:0]                req_origin_x,
   input  wire logic signed [31:0]                req_origin_y,
   input  wire logic [30:0]                       req_rect_width,
   input  wire logic [30:0]                       req_rect_height,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [31:0]                     rsp_p0_x,
   output logic signed [31:0]                     rsp_p0_y,
   output logic signed [31:0]                     rsp_p1_x,
   output logic signed [31:0]                     rsp_p1_y,
   output logic signed [31:0]                     rsp_p2_x,
   output logic signed [31:0]                     rsp_p2_y,
   output logic signed [31:0]                     rsp_p3_x,
   output logic signed [31:0]                     rsp_p3_y,
   output logic                                   rsp_saturated,
   input  wire logic                              csr_we,
   input  wire logic [raff_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [31:0]                       csr_wdata
);

   raff_pkg::cfg_type    cfg_ff, cfg_in;
   raff_pkg::head_type   fr_head;
   raff_pkg::bk_ctl_type bk_ctl;
   raff_pkg::rsp_type    rsp_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            raff_pkg::CSR_MOVE_STEP:     cfg_in.move_step     = csr_wdata[30:0];
            raff_pkg::CSR_GROW_FACTOR:   cfg_in.grow_factor   = csr_wdata[30:0];
            raff_pkg::CSR_SHRINK_FACTOR: cfg_in.shrink_factor = csr_wdata[30:0];
            raff_pkg::CSR_ROT_COSINE:    cfg_in.rot_cosine    = $signed(csr_wdata);
            raff_pkg::CSR_ROT_SINE:      cfg_in.rot_sine      = $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.move_step     <= raff_pkg::RST_MOVE_STEP;
         cfg_ff.grow_factor   <= raff_pkg::RST_GROW_FACTOR;
         cfg_ff.shrink_factor <= raff_pkg::RST_SHRINK_FACTOR;
         cfg_ff.rot_cosine    <= raff_pkg::RST_ROT_COSINE;
         cfg_ff.rot_sine      <= raff_pkg::RST_ROT_SINE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   raff_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_origin_x    (req_origin_x),
      .req_origin_y    (req_origin_y),
      .req_rect_width  (req_rect_width),
      .req_rect_height (req_rect_height),
      .pop             (bk_ctl.pop),
      .head            (fr_head)
   );

   raff_back #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (fr_head),
      .ctl       (bk_ctl),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_p0_x      = rsp_data.x[0];
   assign rsp_p0_y      = rsp_data.y[0];
   assign rsp_p1_x      = rsp_data.x[1];
   assign rsp_p1_y      = rsp_data.y[1];
   assign rsp_p2_x      = rsp_data.x[2];
   assign rsp_p2_y      = rsp_data.y[2];
   assign rsp_p3_x      = rsp_data.x[3];
   assign rsp_p3_y      = rsp_data.y[3];
   assign rsp_saturated = rsp_data.saturated;

`ifndef NO_ASSERTIONS
   // the back never takes an entry from an empty queue
   a_pop_needs_entry: assert property (@(posedge clock) disable iff (reset)
      bk_ctl.pop |-> fr_head.valid)
      else $error("queue popped while empty");

   // no entry is taken while a scale or rotate is in flight
   a_no_pop_when_busy: assert property (@(posedge clock) disable iff (reset)
      bk_ctl.busy |-> !bk_ctl.pop)
      else $error("queue popped during a multi-cycle transform");

   // a finished item never overwrites a result that is still waiting
   a_finish_needs_room: assert property (@(posedge clock) disable iff (reset)
      bk_ctl.finish |-> (!rsp_valid || rsp_ready))
      else $error("result overwritten before it was taken");

   a_finish_shows_result: assert property (@(posedge clock) disable iff (reset)
      bk_ctl.finish |=> rsp_valid)
      else $error("finished item did not reach the result register");
`endif

endmodule

`default_nettype wire
